/* rtl/core/ets_pkg.sv */
// Package for the edge timing statistics core: payload structs, request codes,
// ring depths and reset constants. No dependencies.
`default_nettype none
package ets_pkg;
    localparam int PULSE_DEPTH = 64;
    localparam int RISE_DEPTH  = 16;
    localparam int PW = $clog2(PULSE_DEPTH);
    localparam int RW = $clog2(RISE_DEPTH);

    localparam logic [31:0] GAP_RESET = 32'd5000;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        REQ_EDGE  = 3'd0,
        REQ_TAIL  = 3'd1,
        REQ_CLEAR = 3'd2,
        REQ_START = 3'd3,
        REQ_PULSE = 3'd4,
        REQ_RISE  = 3'd5
    } req_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        level;
        logic [31:0] time_us;
        logic [5:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [31:0] edge_count;
        logic [31:0] high_time;
        logic [31:0] low_time;
        logic [31:0] min_pulse;
        logic [31:0] max_pulse;
        logic [31:0] burst_count;
        logic [31:0] burst_edge_count;
        logic [31:0] max_gap;
        logic        max_gap_was_high;
        logic [6:0]  pulse_entries;
        logic [31:0] read_data;
        logic        read_valid;
    } out_item_t;

    // classified operation passed from front to back
    typedef struct packed {
        logic        is_edge;
        logic        is_tail;
        logic        is_clear;
        logic        set_level;
        logic        is_pulse_rd;
        logic        is_rise_rd;
        logic        level;
        logic [31:0] time_us;
        logic [5:0]  read_index;
    } op_t;
endpackage
`default_nettype wire

/* rtl/core/ets_front.sv */
// Front end: accepts input beats, decodes request type, pushes ops into a
// two-entry queue. Depends on ets_pkg.
`default_nettype none
module ets_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire ets_pkg::in_item_t in_data,
    output logic                  op_valid,
    input  wire logic             op_take,
    output ets_pkg::op_t          op
);
    ets_pkg::op_t q_reg [2];
    logic         rd_ptr_reg, rd_ptr_next;
    logic         wr_ptr_reg, wr_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;
    ets_pkg::op_t dec;
    logic         push, pop;

    // request decode
    always_comb
    begin
        dec = '0;
        dec.level      = in_data.level;
        dec.time_us    = in_data.time_us;
        dec.read_index = in_data.read_index;
        unique case (in_data.req_type)
            ets_pkg::REQ_EDGE:  dec.is_edge = 1'b1;
            ets_pkg::REQ_TAIL:  dec.is_tail = 1'b1;
            ets_pkg::REQ_CLEAR: dec.is_clear = 1'b1;
            ets_pkg::REQ_START:
            begin
                dec.is_clear  = 1'b1;
                dec.set_level = 1'b1;
            end
            ets_pkg::REQ_PULSE: dec.is_pulse_rd = 1'b1;
            ets_pkg::REQ_RISE:  dec.is_rise_rd = 1'b1;
            default: ;
        endcase
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign op_valid = (cnt_reg != 2'd0);
    assign pop      = op_valid && op_take;
    assign op       = q_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= dec;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not advance");
endmodule
`default_nettype wire

/* rtl/core/ets_back.sv */
// Back end: applies ops to statistics and rings, registers one result per op
// with a skid stage toward the output. Depends on ets_pkg.
`default_nettype none
module ets_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [31:0]        gap_threshold,
    input  wire logic               op_valid,
    output logic                    op_take,
    input  wire ets_pkg::op_t       op,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ets_pkg::out_item_t      out_data
);
    localparam int PD = ets_pkg::PULSE_DEPTH;
    localparam int RD = ets_pkg::RISE_DEPTH;
    localparam int PW = ets_pkg::PW;
    localparam int RW = ets_pkg::RW;

    logic        level_reg;
    logic [31:0] last_time_reg;
    logic [31:0] edge_reg, high_reg, low_reg, min_reg, max_reg;
    logic [31:0] gapcnt_reg, short_reg, lgap_reg;
    logic        lgap_lvl_reg;
    logic [PW-1:0] p_head_reg;
    logic [PW:0]   p_held_reg;
    logic [RW-1:0] r_head_reg;
    logic [RW:0]   r_held_reg;
    logic [31:0] pulse_mem [PD];
    logic [31:0] rise_mem [RD];

    // stage 1: statistics update, read addresses and a registered read
    logic        s1_valid_reg;
    logic        s1_pulse_rd_reg, s1_rise_rd_reg, s1_ok_reg;
    logic [31:0] s1_pa_reg, s1_ra_reg, s1_rb_reg;
    logic        adv;

    // output buffer: main + skid
    logic               ob_valid_reg, sk_valid_reg;
    ets_pkg::out_item_t ob_reg, sk_reg;
    ets_pkg::out_item_t res;

    logic [31:0] dt;
    logic        big;
    logic        rise;
    logic [PW-1:0] p_addr;
    logic [RW-1:0] r_addr_a, r_addr_b;
    logic        p_ok, r_ok;

    assign dt   = op.time_us - last_time_reg;
    assign big  = dt >= gap_threshold;
    assign rise = !level_reg && op.level;
    assign p_addr = p_head_reg - p_held_reg[PW-1:0] + op.read_index[PW-1:0];
    assign r_addr_a = r_head_reg - r_held_reg[RW-1:0] + op.read_index[RW-1:0];
    assign r_addr_b = r_addr_a + 1'b1;
    assign p_ok = {1'b0, op.read_index} < 7'(p_held_reg);
    assign r_ok = ({1'b0, op.read_index} + 7'd1) < 7'(r_held_reg);

    // accept only when skid is free and the s1 result is not about to move
    // into it, so every s1 result always has a place
    assign op_take = !sk_valid_reg && !(s1_valid_reg && ob_valid_reg && out_stall);
    assign adv     = op_valid && op_take;

    // statistics and ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0; last_time_reg <= '0;
            edge_reg <= '0; high_reg <= '0; low_reg <= '0;
            min_reg <= ets_pkg::ALL_ONES; max_reg <= '0;
            gapcnt_reg <= '0; short_reg <= '0; lgap_reg <= '0;
            lgap_lvl_reg <= 1'b0;
            p_head_reg <= '0; p_held_reg <= '0;
            r_head_reg <= '0; r_held_reg <= '0;
        end
        else if (adv)
        begin
            if (op.is_edge)
            begin
                if (level_reg) high_reg <= high_reg + dt;
                else low_reg <= low_reg + dt;
                if (dt < min_reg) min_reg <= dt;
                if (dt > max_reg) max_reg <= dt;
                p_head_reg <= p_head_reg + 1'b1;
                if (p_held_reg != (PW+1)'(PD)) p_held_reg <= p_held_reg + 1'b1;
                if (big)
                begin
                    gapcnt_reg <= gapcnt_reg + 32'd1;
                    if (dt > lgap_reg)
                    begin
                        lgap_reg <= dt;
                        lgap_lvl_reg <= level_reg;
                    end
                end
                else
                    short_reg <= short_reg + 32'd1;
                if (rise)
                begin
                    r_head_reg <= r_head_reg + 1'b1;
                    if (r_held_reg != (RW+1)'(RD)) r_held_reg <= r_held_reg + 1'b1;
                end
                edge_reg <= edge_reg + 32'd1;
                level_reg <= op.level;
                last_time_reg <= op.time_us;
            end
            else if (op.is_tail)
            begin
                if (level_reg) high_reg <= high_reg + dt;
                else low_reg <= low_reg + dt;
                if (big && dt > lgap_reg)
                begin
                    lgap_reg <= dt;
                    lgap_lvl_reg <= level_reg;
                end
                last_time_reg <= op.time_us;
            end
            else if (op.is_clear)
            begin
                if (op.set_level) level_reg <= op.level;
                last_time_reg <= op.time_us;
                edge_reg <= '0; high_reg <= '0; low_reg <= '0;
                min_reg <= ets_pkg::ALL_ONES; max_reg <= '0;
                gapcnt_reg <= '0; short_reg <= '0; lgap_reg <= '0;
                lgap_lvl_reg <= 1'b0;
                p_head_reg <= '0; p_held_reg <= '0;
                r_head_reg <= '0; r_held_reg <= '0;
            end
        end
    end

    // ring memories: one write and registered reads
    always_ff @(posedge clk)
    begin
        if (adv && op.is_edge)
            pulse_mem[p_head_reg] <= dt;
        if (adv && op.is_edge && rise)
            rise_mem[r_head_reg] <= op.time_us;
        if (adv)
        begin
            s1_pa_reg <= pulse_mem[p_addr];
            s1_ra_reg <= rise_mem[r_addr_a];
            s1_rb_reg <= rise_mem[r_addr_b];
            s1_pulse_rd_reg <= op.is_pulse_rd;
            s1_rise_rd_reg  <= op.is_rise_rd;
            s1_ok_reg <= op.is_pulse_rd ? p_ok : r_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_valid_reg <= 1'b0;
        else s1_valid_reg <= adv;
    end

    // assemble result from state after the update
    always_comb
    begin
        res.edge_count       = edge_reg;
        res.high_time        = high_reg;
        res.low_time         = low_reg;
        res.min_pulse        = min_reg;
        res.max_pulse        = max_reg;
        res.burst_count      = gapcnt_reg;
        res.burst_edge_count = short_reg;
        res.max_gap          = lgap_reg;
        res.max_gap_was_high = lgap_lvl_reg;
        res.pulse_entries    = 7'(p_held_reg);
        res.read_data        = '0;
        res.read_valid       = 1'b0;
        if (s1_pulse_rd_reg && s1_ok_reg)
        begin
            res.read_data  = s1_pa_reg;
            res.read_valid = 1'b1;
        end
        else if (s1_rise_rd_reg && s1_ok_reg && s1_rb_reg > s1_ra_reg)
        begin
            res.read_data  = s1_rb_reg - s1_ra_reg;
            res.read_valid = 1'b1;
        end
    end

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
            sk_valid_reg <= 1'b0;
        end
        else
        begin
            if (!ob_valid_reg || !out_stall)
            begin
                ob_valid_reg <= sk_valid_reg || s1_valid_reg;
                sk_valid_reg <= 1'b0;
            end
            else if (s1_valid_reg)
                sk_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ob_valid_reg || !out_stall)
            ob_reg <= sk_valid_reg ? sk_reg : res;
        else if (s1_valid_reg)
            sk_reg <= res;
    end

    assign out_valid = ob_valid_reg;
    assign out_data  = ob_reg;

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        p_held_reg <= (PW+1)'(PD) && r_held_reg <= (RW+1)'(RD))
        else $error("ring fill count out of range");
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        sk_valid_reg |-> ob_valid_reg) else $error("skid full with output empty");
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        sk_valid_reg |-> !s1_valid_reg) else $error("result would be dropped");
endmodule
`default_nettype wire

/* rtl/core/edge_timing_statistics_core.sv */
// Edge timing statistics core, top level: gap threshold register, front
// decoder/queue and back statistics engine. Depends on ets_pkg, ets_front, ets_back.
//
// Usage: input beats (in_valid/in_stall, in_data) carry edge, close tail,
// reset window, start, read pulse and read rise period requests. Each beat
// yields exactly one result beat (out_valid/out_stall, out_data) with all
// statistics after the update plus read data for read requests.
// Throughput: one item per cycle while the output is not stalled, set by the
// subtract/compare/add update in the back end. From accept to result an item
// passes the queue, the update with registered ring read and the output register.
// The threshold port (cfg_valid/cfg_ready) always accepts; write only when
// idle. Reset clears all statistics and sets the threshold to 5000; ring
// contents are undefined until written. When the receiver stalls, results
// fill the output register and skid stage, then the queue, then in_stall
// rises; nothing is lost.
`default_nettype none
module edge_timing_statistics_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire ets_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ets_pkg::out_item_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [31:0]        cfg_data
);
    logic [31:0]  gap_reg;
    logic         op_valid, op_take;
    ets_pkg::op_t op;

    assign cfg_ready = 1'b1;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) gap_reg <= ets_pkg::GAP_RESET;
        else if (cfg_valid && cfg_ready) gap_reg <= cfg_data;
    end

    ets_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .op_valid(op_valid), .op_take(op_take), .op(op)
    );

    ets_back u_back (
        .clk(clk), .rst_n(rst_n), .gap_threshold(gap_reg),
        .op_valid(op_valid), .op_take(op_take), .op(op),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule
`default_nettype wire
